// File: sv/sle_pkg.sv
// Shared types, codes and helper functions for the S-record line encoder.
`timescale 1ns / 1ps

package sle_pkg;

    localparam int unsigned DataWidth   = 32;
    localparam int unsigned AddrWidth   = 4;
    localparam int unsigned ModeWidth   = 2;
    localparam logic [1:0]  ModeReset   = 2'd2;

    localparam logic [1:0]  RegAddressMode  = 2'd0;
    localparam logic [1:0]  RegFirstAddress = 2'd1;
    localparam logic [1:0]  RegEntryAddress = 2'd2;

    localparam logic [1:0]  ModeS1 = 2'd0;
    localparam logic [1:0]  ModeS2 = 2'd1;

    localparam logic [7:0]  CharS = 8'h53;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LETTER,
        ST_DIGIT,
        ST_HI,
        ST_LO
    } state_t;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_CSUM
    } phase_t;

    typedef struct packed {
        logic [ModeWidth-1:0] address_mode;
        logic [31:0]          first_address;
        logic [31:0]          entry_address;
        logic                 load_first;
    } cfg_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h37 + {4'd0, nib};
        return c;
    endfunction

    // Number of address bytes for a mode; mode three counts as S3.
    function automatic logic [2:0] addr_bytes(input logic [ModeWidth-1:0] mode);
        logic [2:0] n;
        unique case (mode)
            ModeS1:  n = 3'd2;
            ModeS2:  n = 3'd3;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

// File: sv/sle_apb_regs.sv
// APB configuration registers of the S-record line encoder.
`timescale 1ns / 1ps

module sle_apb_regs #(
    parameter int unsigned AW = sle_pkg::AddrWidth
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [AW-1:0]              paddr,
    input  logic [sle_pkg::DataWidth-1:0] pwdata,
    output logic [sle_pkg::DataWidth-1:0] prdata,
    output logic                       pready,
    output sle_pkg::cfg_t              cfg
);
    import sle_pkg::*;

    logic [ModeWidth-1:0] mode_reg;
    logic [31:0]          first_reg;
    logic [31:0]          entry_reg;
    logic                 wr_en;
    logic                 load_first;
    logic [1:0]           reg_idx;

    assign pready     = 1'b1;
    assign wr_en      = psel && penable && pwrite && pready;
    assign reg_idx    = paddr[3:2];
    assign load_first = wr_en && (reg_idx == RegFirstAddress);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ModeReset;
            first_reg <= '0;
            entry_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                RegAddressMode:  mode_reg  <= pwdata[ModeWidth-1:0];
                RegFirstAddress: first_reg <= pwdata;
                RegEntryAddress: entry_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            RegAddressMode:  prdata = {{(DataWidth-ModeWidth){1'b0}}, mode_reg};
            RegFirstAddress: prdata = first_reg;
            RegEntryAddress: prdata = entry_reg;
            default:         prdata = '0;
        endcase
    end

    assign cfg.address_mode  = mode_reg;
    // new value passed straight through during its write
    assign cfg.first_address = load_first ? pwdata : first_reg;
    assign cfg.entry_address = entry_reg;
    assign cfg.load_first    = load_first;

endmodule

// File: sv/srecord_line_encoder.sv
// Top level of the Motorola S-record line encoder.
`timescale 1ns / 1ps
//
// Input stream: one transfer per data byte or terminate request (tuser = 1).
// Output stream: one ASCII character per transfer, tlast on the last
// character caused by an input, tuser on the last character of a record.
// APB port: address_mode at 0x0, first_address at 0x4, entry_address at 0x8;
// writing first_address also reloads the running record address.
// Timing: a sequencer emits one character per cycle through an output
// register while the output is not stalled. An input yields n characters,
// where n is
//   plain data byte 2, opening byte 4 + 2*A + 2, closing byte adds 2,
//   terminate record 4 + 2*A + 2, with A = 2, 3 or 4 address bytes.
// The input transfer only loads the sequencer, which then registers the first character;
// the input side is ready again from the edge that registers the last character.
// A stall on the output holds the sequencer and the registered character.
// Reset selects S3 mode, clears the addresses, the running sum and the
// record length, and empties the output register.
//
module srecord_line_encoder #(
    parameter int unsigned AW = sle_pkg::AddrWidth
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [AW-1:0]                 paddr,
    input  logic [sle_pkg::DataWidth-1:0] pwdata,
    output logic [sle_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // data_byte, first_in_record, byte_count
    input  logic                          s_axis_tuser,  // kind
    input  logic                          s_axis_tlast,  // last_in_record
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // character
    output logic                          m_axis_tuser,  // line_end
    output logic                          m_axis_tlast   // last_of_run
);
    import sle_pkg::*;

    cfg_t cfg;

    sle_apb_regs #(.AW(AW)) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  abyte_reg, abyte_next;
    logic        kind_reg, kind_next;
    logic        last_reg, last_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  acc_reg, acc_next;
    logic [31:0] naddr_reg, naddr_next;
    logic [7:0]  rsum_reg, rsum_next;
    logic [7:0]  rlen_reg, rlen_next;

    logic        ovalid_reg, ovalid_next;
    logic [7:0]  ochar_reg, ochar_next;
    logic        oend_reg, oend_next;
    logic        olast_reg, olast_next;

    logic        accept;
    logic        fire;
    logic [2:0]  nab;
    logic [7:0]  cur_byte;
    logic [31:0] addr_src;
    logic [7:0]  addr_byte;
    logic [7:0]  digit;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = (state_reg != ST_IDLE) && (!ovalid_reg || m_axis_tready);
    assign nab           = addr_bytes(cfg.address_mode);

    always_comb
    begin
        if (kind_reg)
            addr_src = (nab == 3'd4) ? cfg.entry_address : 32'd0;
        else
            addr_src = naddr_reg;
        unique case (abyte_reg)
            2'd0: addr_byte = addr_src[7:0];
            2'd1: addr_byte = addr_src[15:8];
            2'd2: addr_byte = addr_src[23:16];
            2'd3: addr_byte = addr_src[31:24];
        endcase
        unique case (phase_reg)
            PH_COUNT: cur_byte = (kind_reg ? 8'd0 : count_reg) + {5'd0, nab} + 8'd1;
            PH_ADDR:  cur_byte = addr_byte;
            PH_DATA:  cur_byte = data_reg;
            PH_CSUM:  cur_byte = ~acc_reg;
        endcase
        unique case (nab)
            3'd2:    digit = kind_reg ? 8'h39 : 8'h31;
            3'd3:    digit = kind_reg ? 8'h38 : 8'h32;
            default: digit = kind_reg ? 8'h37 : 8'h33;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        abyte_next  = abyte_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;
        data_next   = data_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        naddr_next  = naddr_reg;
        rsum_next   = rsum_reg;
        rlen_next   = rlen_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        ochar_next  = ochar_reg;
        oend_next   = oend_reg;
        olast_next  = olast_reg;

        if (cfg.load_first)
            naddr_next = cfg.first_address;

        if (accept)
        begin
            kind_next  = s_axis_tuser;
            last_next  = s_axis_tlast;
            data_next  = s_axis_tdata[7:0];
            count_next = s_axis_tdata[16:9];
            if (s_axis_tuser || s_axis_tdata[8])
            begin
                acc_next   = 8'd0;
                state_next = ST_LETTER;
                if (!s_axis_tuser)
                    rlen_next = s_axis_tdata[16:9];
            end
            else
            begin
                acc_next   = rsum_reg;
                phase_next = PH_DATA;
                state_next = ST_HI;
            end
        end
        else if (fire)
        begin
            ovalid_next = 1'b1;
            oend_next   = 1'b0;
            olast_next  = 1'b0;
            unique case (state_reg)
                ST_LETTER:
                begin
                    ochar_next = CharS;
                    state_next = ST_DIGIT;
                end
                ST_DIGIT:
                begin
                    ochar_next = digit;
                    phase_next = PH_COUNT;
                    state_next = ST_HI;
                end
                ST_HI:
                begin
                    ochar_next = hex_char(cur_byte[7:4]);
                    state_next = ST_LO;
                end
                ST_LO:
                begin
                    ochar_next = hex_char(cur_byte[3:0]);
                    state_next = ST_HI;
                    if (phase_reg != PH_CSUM)
                        acc_next = acc_reg + cur_byte;
                    unique case (phase_reg)
                        PH_COUNT:
                        begin
                            phase_next = PH_ADDR;
                            abyte_next = 2'(nab - 3'd1);
                        end
                        PH_ADDR:
                        begin
                            if (abyte_reg == 2'd0)
                                phase_next = kind_reg ? PH_CSUM : PH_DATA;
                            else
                                abyte_next = abyte_reg - 2'd1;
                        end
                        PH_DATA:
                        begin
                            rsum_next = acc_reg + cur_byte;
                            if (last_reg)
                                phase_next = PH_CSUM;
                            else
                            begin
                                olast_next = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        PH_CSUM:
                        begin
                            oend_next  = 1'b1;
                            olast_next = 1'b1;
                            state_next = ST_IDLE;
                            if (!kind_reg)
                                naddr_next = naddr_reg + {24'd0, rlen_reg};
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_COUNT;
            ovalid_reg <= 1'b0;
            naddr_reg  <= '0;
            rsum_reg   <= '0;
            rlen_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
            naddr_reg  <= naddr_next;
            rsum_reg   <= rsum_next;
            rlen_reg   <= rlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        abyte_reg <= abyte_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        data_reg  <= data_next;
        count_reg <= count_next;
        acc_reg   <= acc_next;
        ochar_reg <= ochar_next;
        oend_reg  <= oend_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tuser  = oend_reg;
    assign m_axis_tlast  = olast_reg;

endmodule
